/* rtl/clock_edge_time_calculator_unit_assert.svh */
// assertion macros for the clock edge time calculator
`ifndef CLOCK_EDGE_TIME_CALCULATOR_UNIT_ASSERT_SVH
`define CLOCK_EDGE_TIME_CALCULATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define CETC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define CETC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cetc_pkg.sv */
// shared constants, codes, types and the divider step of the clock edge time calculator
package cetc_pkg;

  localparam int OP_WIDTH           = 3;
  localparam int TICK_PORT_WIDTH    = 64;
  localparam int PERIOD_WIDTH       = 32;
  localparam int PHASE_WIDTH        = 32;
  localparam int SYNC_WIDTH         = 8;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int CFG_DATA_WIDTH     = 32;
  localparam int TICK_WIDTH_DEFAULT = 64;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd1;
  localparam logic [PHASE_WIDTH-1:0]  PHASE_RESET  = 32'd0;
  localparam logic [SYNC_WIDTH-1:0]   SYNC_RESET   = 8'd2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_IS_EDGE          = 3'd0,
    OP_EDGE_AT_OR_AFTER = 3'd1,
    OP_EDGE_AFTER       = 3'd2,
    OP_CYCLE_OF         = 3'd3,
    OP_TICK_OF_CYCLE    = 3'd4,
    OP_ADVANCE          = 3'd5,
    OP_CROSS_INTO       = 3'd6
  } op_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CLOCK_PERIOD = 2'd0,
    CFG_PHASE_OFFSET = 2'd1,
    CFG_SYNC_DEPTH   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [TICK_PORT_WIDTH-1:0] result_value;
    logic                       edge_flag;
  } answer_t;

  // one restoring division step: returns {new remainder, quotient bit}
  function automatic logic [PERIOD_WIDTH:0] div_step(
    input logic [PERIOD_WIDTH-1:0] rem,
    input logic                    in_bit,
    input logic [PERIOD_WIDTH-1:0] divisor
  );
    logic [PERIOD_WIDTH:0] trial;
    logic [PERIOD_WIDTH:0] diff;
    trial = {rem, in_bit};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      return {diff[PERIOD_WIDTH-1:0], 1'b1};
    end else begin
      return {trial[PERIOD_WIDTH-1:0], 1'b0};
    end
  endfunction

endpackage

/* rtl/cetc_ifs.sv */
// query and answer channel interfaces of the clock edge time calculator
interface cetc_query_if import cetc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_WIDTH-1:0]        op;
  logic [TICK_PORT_WIDTH-1:0] tick_value;
  logic [TICK_PORT_WIDTH-1:0] cycle_count;

  modport source (output valid, output op, output tick_value, output cycle_count, input ready);
  modport sink   (input valid, input op, input tick_value, input cycle_count, output ready);
endinterface

interface cetc_answer_if import cetc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TICK_PORT_WIDTH-1:0] result_value;
  logic                       edge_flag;

  modport source (output valid, output result_value, output edge_flag, input ready);
  modport sink   (input valid, input result_value, input edge_flag, output ready);
endinterface

/* rtl/clock_edge_time_calculator_unit.sv */
// top level of the clock edge time calculator: config registers, divider pipeline, output skid
// Answers one time query per transaction for a single clock domain set up by clock_period,
// phase_offset and sync_depth (written through cfg_we/cfg_index/cfg_data; a zero period write
// is dropped). The block takes one query transaction per clock unless the pipeline holds, and
// returns exactly one answer transaction per query, in order. Every query runs the same fixed
// pipeline: sixteen stages reduce the phase modulo the period two bits at a time, one stage
// subtracts the phase from the tick, ceil(TICK_WIDTH/2) stages divide by the period two
// quotient bits each, then one stage picks the operands, one multiplies and a final adder loads
// the output register. A skid register behind the output register keeps query.ready high while
// a single answer waits; only when both are full does the whole pipeline hold. The pipeline
// reads the config registers live, so they are to be written by the user only while no query is
// in flight; the block itself does not enforce this. There are no memories and no clearing pass.
`include "clock_edge_time_calculator_unit_assert.svh"

module clock_edge_time_calculator_unit import cetc_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  cetc_query_if.sink                 query,
  cetc_answer_if.source              answer
);

  // two quotient bits per divider stage
  localparam int STEPS_PER_STAGE = 2;
  localparam int PH_STAGES  = (PHASE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_STAGES = (TICK_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SUB_STAGE  = PH_STAGES;
  localparam int NF         = PH_STAGES + 1 + DIV_STAGES;

  localparam logic [TICK_WIDTH-1:0] TICK_ONE = TICK_WIDTH'(1);

  // payload of one front stage (phase reduction, subtract, tick division)
  typedef struct packed {
    logic [OP_WIDTH-1:0]     op;
    logic [TICK_WIDTH-1:0]   t;
    logic [TICK_WIDTH-1:0]   c;
    logic [PERIOD_WIDTH-1:0] prem;
    logic [PHASE_WIDTH-1:0]  pshift;
    logic [TICK_WIDTH-1:0]   phm;
    logic                    lt;
    logic                    eq;
    logic [PERIOD_WIDTH-1:0] rem;
    logic [TICK_WIDTH-1:0]   qd;
  } front_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [PERIOD_WIDTH-1:0] clock_period;
  logic [PHASE_WIDTH-1:0]  phase_offset;
  logic [SYNC_WIDTH-1:0]   sync_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_period <= PERIOD_RESET;
      phase_offset <= PHASE_RESET;
      sync_depth   <= SYNC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_PERIOD: begin
          // a zero period would break the divider, keep the old one
          if (cfg_data != '0) begin
            clock_period <= cfg_data[PERIOD_WIDTH-1:0];
          end
        end
        CFG_PHASE_OFFSET: begin
          phase_offset <= cfg_data[PHASE_WIDTH-1:0];
        end
        CFG_SYNC_DEPTH: begin
          sync_depth <= cfg_data[SYNC_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: everything moves unless the skid register is holding
  // ---------------------------------------------------------------------------
  logic    advance;
  logic    skid_valid;
  answer_t skid_data;
  logic    out_valid;
  answer_t out_data;

  assign advance     = !skid_valid;
  assign query.ready = advance;

  // ---------------------------------------------------------------------------
  // front stages
  // ---------------------------------------------------------------------------
  front_t st       [NF];
  logic   st_valid [NF];
  front_t entry;

  // a fresh transaction carries the masked tick and the raw phase to reduce
  always_comb begin
    entry        = '0;
    entry.op     = query.op;
    entry.t      = query.tick_value[TICK_WIDTH-1:0];
    entry.c      = query.cycle_count[TICK_WIDTH-1:0];
    entry.pshift = phase_offset;
  end

  for (genvar s = 0; s < NF; s++) begin : g_stage
    front_t stage_in;
    front_t stage_next;
    logic   stage_in_valid;

    if (s == 0) begin : g_src_entry
      assign stage_in       = entry;
      assign stage_in_valid = query.valid;
    end else begin : g_src_prev
      assign stage_in       = st[s-1];
      assign stage_in_valid = st_valid[s-1];
    end

    if (s < SUB_STAGE) begin : g_phase
      // phase modulo period, restoring division on the 32-bit phase
      always_comb begin
        logic [PERIOD_WIDTH:0] res;
        res        = '0;
        stage_next = stage_in;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          if (s * STEPS_PER_STAGE + j < PHASE_WIDTH) begin
            res               = div_step(stage_next.prem, stage_next.pshift[PHASE_WIDTH-1],
                                         clock_period);
            stage_next.prem   = res[PERIOD_WIDTH:1];
            stage_next.pshift = {stage_next.pshift[PHASE_WIDTH-2:0], 1'b0};
          end
        end
      end
    end else if (s == SUB_STAGE) begin : g_sub
      // effective phase masked to the tick width, tick minus phase
      always_comb begin
        logic [TICK_PORT_WIDTH-1:0] ph_wide;
        ph_wide        = {{(TICK_PORT_WIDTH-PERIOD_WIDTH){1'b0}}, stage_in.prem};
        stage_next     = stage_in;
        stage_next.phm = ph_wide[TICK_WIDTH-1:0];
        stage_next.lt  = stage_in.t < ph_wide[TICK_WIDTH-1:0];
        stage_next.eq  = stage_in.t == ph_wide[TICK_WIDTH-1:0];
        stage_next.qd  = stage_in.t - ph_wide[TICK_WIDTH-1:0];
        stage_next.rem = '0;
      end
    end else begin : g_div
      // (tick - phase) / period, quotient shifts into qd
      always_comb begin
        logic [PERIOD_WIDTH:0] res;
        res        = '0;
        stage_next = stage_in;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          if ((s - SUB_STAGE - 1) * STEPS_PER_STAGE + j < TICK_WIDTH) begin
            res            = div_step(stage_next.rem, stage_next.qd[TICK_WIDTH-1], clock_period);
            stage_next.rem = res[PERIOD_WIDTH:1];
            stage_next.qd  = {stage_next.qd[TICK_WIDTH-2:0], res[0]};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (advance) begin
        st_valid[s] <= stage_in_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[s] <= stage_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // operand select: every query becomes base + mult * period
  // ---------------------------------------------------------------------------
  front_t                     last;
  logic [TICK_PORT_WIDTH-1:0] period_wide;
  logic [TICK_PORT_WIDTH-1:0] rem_wide;
  logic [TICK_PORT_WIDTH-1:0] sync_wide;
  logic [TICK_WIDTH-1:0]      period_t;
  logic [TICK_WIDTH-1:0]      rem_t;
  logic [TICK_WIDTH-1:0]      edge_at_or_after;
  logic                       at_or_before;
  logic                       rem_zero;
  logic [TICK_WIDTH-1:0]      base_next;
  logic [TICK_WIDTH-1:0]      mult_next;
  logic                       flag_next;

  assign last         = st[NF-1];
  assign period_wide  = {{(TICK_PORT_WIDTH-PERIOD_WIDTH){1'b0}}, clock_period};
  assign rem_wide     = {{(TICK_PORT_WIDTH-PERIOD_WIDTH){1'b0}}, last.rem};
  assign sync_wide    = {{(TICK_PORT_WIDTH-SYNC_WIDTH){1'b0}}, sync_depth};
  assign period_t     = period_wide[TICK_WIDTH-1:0];
  assign rem_t        = rem_wide[TICK_WIDTH-1:0];
  assign at_or_before = last.lt || last.eq;
  assign rem_zero     = (last.rem == '0);

  // next edge at or after the tick; the phase itself when the tick is not past it
  assign edge_at_or_after = at_or_before ? last.phm :
                            rem_zero     ? last.t   :
                                           last.t + period_t - rem_t;

  always_comb begin
    base_next = '0;
    mult_next = '0;
    flag_next = 1'b0;
    case (last.op)
      OP_IS_EDGE: begin
        flag_next = !last.lt && rem_zero;
      end
      OP_EDGE_AT_OR_AFTER: begin
        base_next = edge_at_or_after;
      end
      OP_EDGE_AFTER: begin
        base_next = last.phm;
        mult_next = last.lt ? '0 : last.qd + TICK_ONE;
      end
      OP_CYCLE_OF: begin
        base_next = at_or_before ? '0 : last.qd;
      end
      OP_TICK_OF_CYCLE: begin
        base_next = last.phm;
        mult_next = last.c;
      end
      OP_ADVANCE: begin
        base_next = last.t;
        mult_next = last.c;
      end
      OP_CROSS_INTO: begin
        base_next = edge_at_or_after;
        mult_next = sync_wide[TICK_WIDTH-1:0];
      end
      default: begin
        // unused op code answers zero
      end
    endcase
  end

  logic                  f1_valid;
  logic [TICK_WIDTH-1:0] f1_base;
  logic [TICK_WIDTH-1:0] f1_mult;
  logic                  f1_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (advance) begin
      f1_valid <= st_valid[NF-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_base <= base_next;
      f1_mult <= mult_next;
      f1_flag <= flag_next;
    end
  end

  // ---------------------------------------------------------------------------
  // multiply: mult split in two 32-bit halves against the 32-bit period
  // ---------------------------------------------------------------------------
  logic [TICK_PORT_WIDTH-1:0] mult_wide;
  logic [PERIOD_WIDTH-1:0]    mult_lo;
  logic [PERIOD_WIDTH-1:0]    mult_hi;
  logic [TICK_PORT_WIDTH-1:0] prod_lo;
  logic [PERIOD_WIDTH-1:0]    prod_hi;

  assign mult_wide = TICK_PORT_WIDTH'(f1_mult);
  assign mult_lo   = mult_wide[PERIOD_WIDTH-1:0];
  assign mult_hi   = mult_wide[TICK_PORT_WIDTH-1:PERIOD_WIDTH];
  assign prod_lo   = TICK_PORT_WIDTH'(mult_lo) * TICK_PORT_WIDTH'(clock_period);
  // only the low half of the upper product survives the wrap
  assign prod_hi   = mult_hi * clock_period;

  logic                       f2_valid;
  logic [TICK_WIDTH-1:0]      f2_base;
  logic [TICK_PORT_WIDTH-1:0] f2_lo;
  logic [PERIOD_WIDTH-1:0]    f2_hi;
  logic                       f2_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (advance) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f2_base <= f1_base;
      f2_lo   <= prod_lo;
      f2_hi   <= prod_hi;
      f2_flag <= f1_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // final sum, wrapped to the tick width
  // ---------------------------------------------------------------------------
  logic [TICK_PORT_WIDTH-1:0] scaled;
  logic [TICK_WIDTH-1:0]      sum_t;
  answer_t                    pipe_out;

  assign scaled                = f2_lo + {f2_hi, {PERIOD_WIDTH{1'b0}}};
  assign sum_t                 = f2_base + scaled[TICK_WIDTH-1:0];
  assign pipe_out.result_value = TICK_PORT_WIDTH'(sum_t);
  assign pipe_out.edge_flag    = f2_flag;

  // ---------------------------------------------------------------------------
  // output register with one skid entry behind it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // pipeline is frozen, drain the skid entry first
      if (answer.ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || answer.ready) begin
      out_valid <= f2_valid;
    end else if (f2_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (answer.ready) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || answer.ready) begin
      out_data <= pipe_out;
    end else begin
      skid_data <= pipe_out;
    end
  end

  assign answer.valid        = out_valid;
  assign answer.result_value = out_data.result_value;
  assign answer.edge_flag    = out_data.edge_flag;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CETC_ASSERT_NOW(a_skid_behind_output, skid_valid, out_valid, "skid entry without a waiting answer")
  `CETC_ASSERT_NOW(a_edge_flag_zero_result, answer.valid && answer.edge_flag, answer.result_value == '0, "is_edge answer with nonzero result")
  `CETC_ASSERT_NEXT(a_zero_period_dropped, cfg_we && (cfg_index == CFG_CLOCK_PERIOD) && (cfg_data == '0), $stable(clock_period), "zero period write changed the period")

endmodule
